FILE: hw/rtl/blae_pkg.sv
package blae_pkg;

  localparam int DEPTH_DEF = 128;
  localparam int WIDTH_DEF = 32;

  // control field width, wide enough for any count up to the largest depth
  localparam int CTL_W = 13;

  localparam logic [2:0] MODE_APPEND = 3'd0;
  localparam logic [2:0] MODE_REMOVE = 3'd1;
  localparam logic [2:0] MODE_INSERT = 3'd2;
  localparam logic [2:0] MODE_ERASE  = 3'd3;
  localparam logic [2:0] MODE_FIND   = 3'd4;
  localparam logic [2:0] MODE_SORT   = 3'd5;
  localparam logic [2:0] MODE_READ   = 3'd6;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_BADIDX   = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  localparam logic [7:0] FOUND_NONE = 8'hFF;

  localparam logic [2:0] C_HOLD   = 3'd0;
  localparam logic [2:0] C_APPEND = 3'd1;
  localparam logic [2:0] C_INSERT = 3'd2;
  localparam logic [2:0] C_ERASE  = 3'd3;
  localparam logic [2:0] C_SORT   = 3'd4;

  typedef struct packed {
    logic [2:0]        mode;
    logic signed [31:0] value;
    logic [7:0]        index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] data_value;
    logic signed [7:0]  found_index;
    logic [7:0]         count;
  } out_item_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic [2:0]       op;
    logic             phase;
    logic [CTL_W-1:0] cnt;
    logic [CTL_W-1:0] pos;
    logic [CTL_W-1:0] rd_addr;
  } cell_ctl_t;

endpackage

FILE: hw/rtl/blae_cell.sv
module blae_cell import blae_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  parameter int WIDTH = WIDTH_DEF,
  parameter int IDX   = 0
) (
  input  logic                             clk,
  input  cell_ctl_t                        ctl_i,
  input  logic signed [WIDTH-1:0]          val_i,
  input  logic signed [WIDTH-1:0]          left_i,
  input  logic signed [WIDTH-1:0]          right_i,
  input  logic                             swap_i,
  input  logic                             hit_i,
  output logic signed [WIDTH-1:0]          data_o,
  output logic                             swap_o,
  output logic                             hit_o,
  output logic signed [WIDTH-1:0]          rd_o,
  output logic [$clog2(DEPTH)-1:0]         fidx_o
);

  localparam int IW = $clog2(DEPTH);
  localparam logic [CTL_W-1:0] ME    = CTL_W'(IDX);
  localparam logic [CTL_W-1:0] ME_UP = CTL_W'(IDX + 1);
  localparam logic             PAR   = 1'(IDX % 2);

  logic signed [WIDTH-1:0] data_r;
  logic signed [WIDTH-1:0] data_nxt;
  logic                    match;

  assign data_o = data_r;

  // lower cell of an active pair swaps with its right neighbor when out of order
  assign swap_o = (ctl_i.op == C_SORT) && (ctl_i.phase == PAR) && (ME_UP < ctl_i.cnt) &&
                  (right_i < data_r);

  assign match  = (data_r == val_i) && (ME < ctl_i.cnt);
  assign hit_o  = hit_i | match;
  assign fidx_o = (match && !hit_i) ? IW'(IDX) : '0;
  assign rd_o   = (ctl_i.rd_addr == ME) ? data_r : '0;

  always_comb begin
    data_nxt = data_r;
    unique case (ctl_i.op)
      C_APPEND: begin
        if (ME == ctl_i.cnt) data_nxt = val_i;
      end
      C_INSERT: begin
        if (ME == ctl_i.pos) begin
          data_nxt = val_i;
        end else if (ME > ctl_i.pos && ME <= ctl_i.cnt) begin
          data_nxt = left_i;
        end
      end
      C_ERASE: begin
        if (ME >= ctl_i.pos) data_nxt = right_i;
      end
      C_SORT: begin
        if (swap_o) begin
          data_nxt = right_i;
        end else if (swap_i) begin
          data_nxt = left_i;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

FILE: hw/rtl/bounded_array_list_engine.sv
// Channel | Ports                           | Transaction
// --------+---------------------------------+-----------------------------------
// input   | in_valid, in_stall, in_data     | one list operation
// output  | out_valid, out_stall, out_data  | status, data, found index, count
//
// Append, remove, insert, erase, find and read give their result in the cycle
// after acceptance: the cell chain shifts, compares or reads every entry at once and the result is registered.
// Sort of two or more entries runs odd-even transposition passes over the chain,
// one pass a cycle and count passes in all after it is accepted; a shorter list
// gives its result in the cycle after acceptance, like the other operations.
// Reset clears only the entry count, sort state and handshake state; the cell
// words are not reset. in_stall is high while a sort runs or a result stalls.
module bounded_array_list_engine import blae_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  parameter int WIDTH = WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int CNTW = $clog2(DEPTH + 1);
  localparam int IW   = $clog2(DEPTH);

  logic [CNTW-1:0] count_r, count_nxt;
  logic [CNTW-1:0] pass_r, pass_nxt;
  logic            sort_r, sort_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_item_r, out_item_nxt;

  cell_ctl_t               ctl;
  logic signed [WIDTH-1:0] val_w;
  logic signed [WIDTH-1:0] data_w [DEPTH];
  logic signed [WIDTH-1:0] rd_w   [DEPTH];
  logic [IW-1:0]           fidx_w [DEPTH];
  logic [DEPTH-1:0]        swap_c;
  logic [DEPTH:0]          hit_c;
  logic signed [WIDTH-1:0] rd_bus;
  logic [IW-1:0]           fidx_bus;

  logic             in_acc;
  logic             sort_last;
  logic [CTL_W-1:0] cnt_ext, idx_ext;
  logic             full, empty;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = sort_r || (out_valid_r && out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  assign cnt_ext   = CTL_W'(count_r);
  assign idx_ext   = CTL_W'(in_data.index);
  assign full      = (count_r == CNTW'(DEPTH));
  assign empty     = (count_r == '0);
  assign val_w     = WIDTH'(in_data.value);
  assign sort_last = sort_r && (pass_r == count_r - CNTW'(1));

  assign hit_c[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [WIDTH-1:0] left_w, right_w;
    logic                    swap_in;
    if (i == 0) begin : g_first
      assign left_w  = data_w[i];
      assign swap_in = 1'b0;
    end else begin : g_mid
      assign left_w  = data_w[i-1];
      assign swap_in = swap_c[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = data_w[i];
    end else begin : g_nlast
      assign right_w = data_w[i+1];
    end

    blae_cell #(
      .DEPTH (DEPTH),
      .WIDTH (WIDTH),
      .IDX   (i)
    ) u_cell (
      .clk     (clk),
      .ctl_i   (ctl),
      .val_i   (val_w),
      .left_i  (left_w),
      .right_i (right_w),
      .swap_i  (swap_in),
      .hit_i   (hit_c[i]),
      .data_o  (data_w[i]),
      .swap_o  (swap_c[i]),
      .hit_o   (hit_c[i+1]),
      .rd_o    (rd_w[i]),
      .fidx_o  (fidx_w[i])
    );
  end

  // at most one cell drives each bus, so OR them together
  always_comb begin
    rd_bus   = '0;
    fidx_bus = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_bus   = rd_bus | rd_w[i];
      fidx_bus = fidx_bus | fidx_w[i];
    end
  end

  always_comb begin
    ctl.op      = C_HOLD;
    ctl.phase   = pass_r[0];
    ctl.cnt     = cnt_ext;
    ctl.pos     = idx_ext;
    ctl.rd_addr = (in_data.mode == MODE_REMOVE) ? (cnt_ext - CTL_W'(1)) : idx_ext;

    count_nxt     = count_r;
    sort_nxt      = sort_r;
    pass_nxt      = pass_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;

    if (sort_r) begin
      ctl.op   = C_SORT;
      pass_nxt = pass_r + CNTW'(1);
      if (sort_last) begin
        sort_nxt                 = 1'b0;
        out_valid_nxt            = 1'b1;
        out_item_nxt.status      = ST_OK;
        out_item_nxt.data_value  = '0;
        out_item_nxt.found_index = FOUND_NONE;
        out_item_nxt.count       = 8'(count_r);
      end
    end else if (in_acc) begin
      out_valid_nxt            = 1'b1;
      out_item_nxt.status      = ST_OK;
      out_item_nxt.data_value  = '0;
      out_item_nxt.found_index = FOUND_NONE;
      unique case (in_data.mode)
        MODE_APPEND: begin
          if (full) begin
            out_item_nxt.status = ST_FULL;
          end else begin
            ctl.op    = C_APPEND;
            count_nxt = count_r + CNTW'(1);
          end
        end
        MODE_REMOVE: begin
          if (empty) begin
            out_item_nxt.status = ST_EMPTY;
          end else begin
            count_nxt               = count_r - CNTW'(1);
            out_item_nxt.data_value = 32'(rd_bus);
          end
        end
        MODE_INSERT: begin
          if (idx_ext > cnt_ext) begin
            out_item_nxt.status = ST_BADIDX;
          end else if (full) begin
            out_item_nxt.status = ST_FULL;
          end else begin
            ctl.op    = C_INSERT;
            count_nxt = count_r + CNTW'(1);
          end
        end
        MODE_ERASE: begin
          if (empty) begin
            out_item_nxt.status = ST_EMPTY;
          end else if (idx_ext >= cnt_ext) begin
            out_item_nxt.status = ST_BADIDX;
          end else begin
            ctl.op    = C_ERASE;
            count_nxt = count_r - CNTW'(1);
          end
        end
        MODE_FIND: begin
          if (hit_c[DEPTH]) begin
            out_item_nxt.found_index = 8'(fidx_bus);
          end else begin
            out_item_nxt.status = ST_NOTFOUND;
          end
        end
        MODE_SORT: begin
          // hold the result back until the last pass
          if (count_r > CNTW'(1)) begin
            sort_nxt      = 1'b1;
            pass_nxt      = '0;
            out_valid_nxt = 1'b0;
          end
        end
        MODE_READ: begin
          if (empty) begin
            out_item_nxt.status = ST_EMPTY;
          end else if (idx_ext >= cnt_ext) begin
            out_item_nxt.status = ST_BADIDX;
          end else begin
            out_item_nxt.data_value = 32'(rd_bus);
          end
        end
        default: out_item_nxt.status = ST_OK;
      endcase
      out_item_nxt.count = 8'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      sort_r      <= 1'b0;
      pass_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      sort_r      <= sort_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

endmodule

FILE: test/blae_checker.sv
module blae_checker import blae_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        failures,
  output int        outstanding,
  output int        checked
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [31:0] list_words [DEPTH_DEF];
  int                 list_held;
  out_item_t          expected_results [$];
  out_item_t          want;

  initial begin
    failures = 0;
    outstanding = 0;
    checked = 0;
    list_held = 0;
  end

  // Apply one list operation to the shadow list and return its result.
  function automatic out_item_t apply_list_op(input in_item_t op);
    out_item_t          res;
    logic signed [31:0] key;
    int                 j;
    bit                 hit;
    res.status = ST_OK;
    res.data_value = '0;
    res.found_index = FOUND_NONE;
    hit = 1'b0;
    case (op.mode)
      MODE_APPEND: begin
        if (list_held >= DEPTH_DEF) begin
          res.status = ST_FULL;
        end else begin
          list_words[list_held] = op.value;
          list_held++;
        end
      end
      MODE_REMOVE: begin
        if (list_held == 0) begin
          res.status = ST_EMPTY;
        end else begin
          list_held--;
          res.data_value = list_words[list_held];
        end
      end
      MODE_INSERT: begin
        if (op.index > list_held) begin
          res.status = ST_BADIDX;
        end else if (list_held >= DEPTH_DEF) begin
          res.status = ST_FULL;
        end else begin
          for (int i = list_held; i > op.index; i--) list_words[i] = list_words[i-1];
          list_words[op.index] = op.value;
          list_held++;
        end
      end
      MODE_ERASE: begin
        if (list_held == 0) begin
          res.status = ST_EMPTY;
        end else if (op.index >= list_held) begin
          res.status = ST_BADIDX;
        end else begin
          list_held--;
          for (int i = op.index; i < list_held; i++) list_words[i] = list_words[i+1];
        end
      end
      MODE_FIND: begin
        res.status = ST_NOTFOUND;
        for (int i = 0; i < list_held; i++) begin
          if (!hit && list_words[i] == op.value) begin
            hit = 1'b1;
            res.found_index = i[7:0];
            res.status = ST_OK;
          end
        end
      end
      MODE_SORT: begin
        // signed ascending; any correct sort yields the same contents
        for (int i = 1; i < list_held; i++) begin
          key = list_words[i];
          j = i;
          while (j > 0 && key < list_words[j-1]) begin
            list_words[j] = list_words[j-1];
            j--;
          end
          list_words[j] = key;
        end
      end
      MODE_READ: begin
        if (list_held == 0) begin
          res.status = ST_EMPTY;
        end else if (op.index >= list_held) begin
          res.status = ST_BADIDX;
        end else begin
          res.data_value = list_words[op.index];
        end
      end
      default: ;
    endcase
    res.count = list_held[7:0];
    return res;
  endfunction

  task automatic compare_field(input string field, input logic signed [63:0] want_v,
                               input logic signed [63:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      expected_results = {expected_results, apply_list_op(in_data)};
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result transaction, expected none, actual %p", $time,
                 out_data);
        failures++;
      end else begin
        want = expected_results.pop_front();
        compare_field("status", want.status, out_data.status);
        compare_field("data_value", want.data_value, out_data.data_value);
        compare_field("found_index", want.found_index, out_data.found_index);
        compare_field("count", want.count, out_data.count);
        checked++;
      end
    end
    outstanding <= expected_results.size();
  end

endmodule

FILE: test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import blae_pkg::*;

  localparam logic [2:0] MODE_UNUSED = 3'd7;
  localparam int FILL_BIAS = 0;
  localparam int EVEN_BIAS = 2;
  localparam int RANDOM_ITEMS = 1550;
  localparam int QUIET_FROM = 1400;
  localparam int LONG_HOLD_CYCLES = 300;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      out_stall = 1'b0;
  in_item_t  in_data = '0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;

  int failures, outstanding, checked;
  int list_len = 0;
  int idle_pct = 0;
  bit long_hold_req = 1'b0;
  int sent = 0, sorts = 0, full_refusals = 0, empty_refusals = 0, bad_index = 0;

  logic signed [31:0] value_pool [8] = '{0, 1, -1, 7, -100, 32'sh7fffffff, 32'sh80000000, 42};
  logic [2:0] mode_order [7] = '{MODE_APPEND, MODE_REMOVE, MODE_INSERT, MODE_ERASE,
                                 MODE_FIND, MODE_SORT, MODE_READ};
  // cumulative percentages per bias, in mode_order
  int mode_cut [3][7] = '{'{55, 59, 84, 88, 93, 95, 98},
                          '{10, 40, 50, 75, 85, 88, 97},
                          '{20, 32, 47, 60, 77, 82, 98}};
  int idle_levels [3] = '{0, 10, 30};

  bounded_array_list_engine uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  blae_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .failures    (failures),
    .outstanding (outstanding),
    .checked     (checked)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #4ms;
    $display("timeout at %0t, %0d results still expected", $time, outstanding);
    $display("Test completed with failures");
    $finish;
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one transaction, hold it until accepted, then maybe go idle.
  task automatic issue(input logic [2:0] mode, input logic signed [31:0] value,
                       input logic [7:0] index);
    in_item_t item;
    item.mode = mode;
    item.value = value;
    item.index = index;
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // track the list length only to aim indexes and tally refusals
    case (mode)
      MODE_APPEND: if (list_len >= DEPTH_DEF) full_refusals++; else list_len++;
      MODE_REMOVE: if (list_len == 0) empty_refusals++; else list_len--;
      MODE_INSERT: begin
        if (index > list_len) bad_index++;
        else if (list_len >= DEPTH_DEF) full_refusals++;
        else list_len++;
      end
      MODE_ERASE: begin
        if (list_len == 0) empty_refusals++;
        else if (index >= list_len) bad_index++;
        else list_len--;
      end
      MODE_READ: begin
        if (list_len == 0) empty_refusals++;
        else if (index >= list_len) bad_index++;
      end
      MODE_SORT: sorts++;
      default: ;
    endcase
    sent++;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic random_item(input int bias);
    int                 roll;
    int                 lim;
    logic [2:0]         mode;
    logic signed [31:0] value;
    logic [7:0]         index;
    roll = $urandom_range(99);
    mode = MODE_UNUSED;
    for (int k = 6; k >= 0; k--) if (roll < mode_cut[bias][k]) mode = mode_order[k];
    // half the values repeat so finds hit and sort sees duplicates
    value = ($urandom_range(1) == 1) ? value_pool[$urandom_range(7)] : $urandom;
    lim = (mode == MODE_INSERT) ? list_len : list_len - 1;
    roll = $urandom_range(99);
    if (roll < 15) index = 8'($urandom_range(255));
    else if (roll < 25) index = (lim + 1 > 255) ? 8'd255 : 8'(lim + 1);
    else if (lim < 0) index = '0;
    else index = 8'($urandom_range(lim));
    issue(mode, value, index);
  endtask

  initial begin
    int n_random;
    int seg;
    int seg_len;
    int bias;
    n_random = 0;
    seg = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    idle_pct = 15;
    issue(MODE_REMOVE, 0, 8'd0);
    issue(MODE_ERASE, 0, 8'd0);
    issue(MODE_READ, 0, 8'd0);
    issue(MODE_FIND, 0, 8'd0);
    issue(MODE_SORT, 0, 8'd0);
    issue(MODE_APPEND, 32'sh7fffffff, 8'd0);
    issue(MODE_SORT, 0, 8'd0);
    issue(MODE_APPEND, 32'sh80000000, 8'd0);
    issue(MODE_INSERT, 0, 8'd0);
    issue(MODE_INSERT, -1, 8'd3);
    issue(MODE_INSERT, 5, 8'd5);
    issue(MODE_READ, 0, 8'd255);
    issue(MODE_ERASE, 0, 8'd200);
    issue(MODE_READ, 0, 8'd1);
    issue(MODE_FIND, -1, 8'd0);
    issue(MODE_FIND, 12345, 8'd0);
    issue(MODE_SORT, 0, 8'd0);
    issue(MODE_READ, 0, 8'd0);
    issue(MODE_READ, 0, 8'd3);
    issue(MODE_ERASE, 0, 8'd0);
    issue(MODE_UNUSED, 32'sh5a5a5a5a, 8'haa);
    issue(MODE_REMOVE, 0, 8'd0);
    issue(MODE_INSERT, 32'sh12345678, 8'h80);
    issue(MODE_INSERT, 32'shffff0000, 8'd0);

    // fill first so the full-list refusals come early, then wander
    while (n_random < RANDOM_ITEMS) begin
      seg_len = $urandom_range(30, 80);
      bias = (seg < 2) ? FILL_BIAS : $urandom_range(EVEN_BIAS);
      idle_pct = (n_random >= QUIET_FROM) ? 0 : idle_levels[$urandom_range(2)];
      if (seg == 3) long_hold_req = 1'b1;
      for (int k = 0; k < seg_len && n_random < RANDOM_ITEMS; k++) begin
        if (n_random == QUIET_FROM) idle_pct = 0;
        random_item(bias);
        n_random++;
      end
      seg++;
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (20) @(posedge clk);

    $display("Covered %0d list operations (%0d sorts), %0d results checked.", sent, sorts,
             checked);
    $display("Refusals driven: %0d on a full list, %0d on an empty list, %0d bad index.",
             full_refusals, empty_refusals, bad_index);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/blae_pkg.sv
hw/rtl/blae_cell.sv
hw/rtl/bounded_array_list_engine.sv
test/blae_checker.sv
test/tb_top.sv
